// ----- hw/rtl/stpk_pkg.sv -----
`timescale 1ns / 1ps
package stpk_pkg;

    localparam int FRAME_BYTES = 256;
    localparam int FRAME_WORDS = FRAME_BYTES / 8;
    localparam int BYTE_W      = $clog2(FRAME_BYTES);
    localparam int WORD_W      = $clog2(FRAME_WORDS);

    // configuration register indexes
    localparam logic [7:0] REG_PAD     = 8'd0;
    localparam logic [7:0] REG_VERSION = 8'd1;

    // record codes and lengths
    localparam logic [7:0] TYPE_IMU = 8'h01;
    localparam logic [7:0] TYPE_PPG = 8'h02;
    localparam logic [7:0] TYPE_TMP = 8'h03;
    localparam logic [7:0] TYPE_CRC = 8'hFE;
    localparam logic [7:0] LEN_IMU  = 8'd12;
    localparam logic [7:0] LEN_PPG  = 8'd10;
    localparam logic [7:0] LEN_TMP  = 8'd2;
    localparam logic [7:0] LEN_CRC  = 8'd2;

    localparam logic [7:0]  HDR_LEN   = 8'd12;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [7:0]  PAD_RESET = 8'hEE;
    localparam logic [7:0]  VER_RESET = 8'h01;

    typedef struct packed {
        logic               imu_present;
        logic               ppg_present;
        logic               temp_present;
        logic [31:0]        uptime_ms;
        logic [47:0]        accel_xyz;
        logic [47:0]        gyro_xyz;
        logic [17:0]        ir_count;
        logic [17:0]        red_count;
        logic [11:0]        pulse_rate_x10;
        logic signed [15:0] temp_centi_c;
    } t_sample;

    typedef struct packed {
        t_sample     s;
        logic [15:0] crc;
    } t_desc;

    // queue handshake between front and back
    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_sts;

    // offset of the checksum record; every record length is even
    function automatic logic [BYTE_W-1:0] crc_offset(input t_sample s);
        logic [BYTE_W-1:0] o;
        o = BYTE_W'(HDR_LEN);
        if (s.imu_present)  o = o + BYTE_W'(14);
        if (s.ppg_present)  o = o + BYTE_W'(12);
        if (s.temp_present) o = o + BYTE_W'(4);
        return o;
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] d);
        logic [15:0] c;
        c = c_in ^ {8'h00, d};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc_two(input logic [15:0] c, input logic [7:0] d0,
                                            input logic [7:0] d1);
        return crc_byte(crc_byte(c, d0), d1);
    endfunction

    // frame byte at address k
    function automatic logic [7:0] frame_byte(input t_sample s, input logic [7:0] ver,
                                              input logic [7:0] pad, input logic [15:0] crc,
                                              input logic [BYTE_W-1:0] k);
        logic [95:0]       hdr;
        logic [111:0]      imu;
        logic [95:0]       ppg;
        logic [31:0]       tmp;
        logic [31:0]       crr;
        logic [BYTE_W-1:0] o_ppg;
        logic [BYTE_W-1:0] o_tmp;
        logic [BYTE_W-1:0] o_crc;
        logic [BYTE_W-1:0] i;
        logic [7:0]        r;
        hdr = {s.uptime_ms, 24'd0, ver, 8'h00, 8'h32, 8'h42, 8'h53};
        imu = {s.gyro_xyz, s.accel_xyz, LEN_IMU, TYPE_IMU};
        ppg = {4'd0, s.pulse_rate_x10, 14'd0, s.red_count, 14'd0, s.ir_count,
               LEN_PPG, TYPE_PPG};
        tmp = {s.temp_centi_c, LEN_TMP, TYPE_TMP};
        crr = {crc, LEN_CRC, TYPE_CRC};
        o_ppg = BYTE_W'(HDR_LEN) + (s.imu_present ? BYTE_W'(14) : '0);
        o_tmp = o_ppg + (s.ppg_present ? BYTE_W'(12) : '0);
        o_crc = o_tmp + (s.temp_present ? BYTE_W'(4) : '0);
        r = pad;
        if (k < BYTE_W'(HDR_LEN)) begin
            r = hdr[{k[3:0], 3'b000} +: 8];
        end else if (s.imu_present && k < BYTE_W'(26)) begin
            i = k - BYTE_W'(HDR_LEN);
            r = imu[{i[3:0], 3'b000} +: 8];
        end else if (s.ppg_present && k >= o_ppg && k < o_ppg + BYTE_W'(12)) begin
            i = k - o_ppg;
            r = ppg[{i[3:0], 3'b000} +: 8];
        end else if (s.temp_present && k >= o_tmp && k < o_tmp + BYTE_W'(4)) begin
            i = k - o_tmp;
            r = tmp[{i[1:0], 3'b000} +: 8];
        end else if (k >= o_crc && k < o_crc + BYTE_W'(4)) begin
            i = k - o_crc;
            r = crr[{i[1:0], 3'b000} +: 8];
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/stpk_front.sv -----
`timescale 1ns / 1ps
module stpk_front import stpk_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  t_sample    i_sample,
    input  logic [7:0] i_version,
    input  t_q_sts     i_q_sts,
    output logic       o_q_push,
    output t_desc      o_desc
);

    logic              r_busy;
    t_sample           r_s;
    logic [15:0]       r_crc;
    logic [BYTE_W-1:0] r_k;
    logic [BYTE_W-1:0] crc_at;
    logic              done;
    logic [7:0]        b0;
    logic [7:0]        b1;

    assign crc_at = crc_offset(r_s);
    assign done   = (r_k == crc_at);
    assign b0 = frame_byte(r_s, i_version, 8'h00, 16'h0000, r_k);
    assign b1 = frame_byte(r_s, i_version, 8'h00, 16'h0000, r_k + BYTE_W'(1));

    assign o_full   = r_busy;
    assign o_q_push = r_busy && done && !i_q_sts.full;
    assign o_desc   = '{s: r_s, crc: r_crc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (!r_busy) begin
            if (i_push) begin
                r_busy <= 1'b1;
            end
        end else if (o_q_push) begin
            r_busy <= 1'b0;
        end
    end

    // checksum runs two bytes a cycle up to the checksum record
    always_ff @(posedge i_clk) begin
        if (!r_busy) begin
            r_s   <= i_sample;
            r_crc <= CRC_INIT;
            r_k   <= '0;
        end else if (!done) begin
            r_crc <= crc_two(r_crc, b0, b1);
            r_k   <= r_k + BYTE_W'(2);
        end
    end

    a_push_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |-> r_k == crc_offset(r_s))
        else $error("descriptor pushed before checksum finished");

    a_push_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |=> !o_full)
        else $error("front still busy after push");

endmodule

// ----- hw/rtl/stpk_queue.sv -----
`timescale 1ns / 1ps
module stpk_queue import stpk_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_q_ctl i_ctl,
    input  t_desc  i_desc,
    output t_q_sts o_sts,
    output t_desc  o_head
);

    t_desc      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_sts.full  = (r_cnt == 2'd2);
    assign o_sts.empty = (r_cnt == 2'd0);
    assign o_head      = r_mem[r_rp];
    assign do_push = i_ctl.push && !o_sts.full;
    assign do_pop  = i_ctl.pop && !o_sts.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("queue count out of range");

    a_cnt_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) == (r_wp != r_rp))
        else $error("queue pointers disagree with count");

endmodule

// ----- hw/rtl/stpk_back.sv -----
`timescale 1ns / 1ps
module stpk_back import stpk_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_desc       i_head,
    input  t_q_sts      i_q_sts,
    output logic        o_q_pop,
    input  logic [7:0]  i_version,
    input  logic [7:0]  i_pad,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_frame_word,
    output logic [4:0]  o_word_index,
    output logic [5:0]  o_bytes_used,
    output logic        o_last
);

    localparam logic [WORD_W-1:0] LAST_W = WORD_W'(FRAME_WORDS - 1);

    logic              r_out_valid;
    logic [WORD_W-1:0] r_widx;
    logic [63:0]       r_word;
    logic [4:0]        r_idx_out;
    logic [5:0]        r_used;
    logic              r_last;
    logic              adv;
    logic [63:0]       n_word;
    logic [BYTE_W-1:0] used_full;

    assign adv     = !i_q_sts.empty && (!r_out_valid || pop);
    assign o_q_pop = adv && (r_widx == LAST_W);
    assign used_full = crc_offset(i_head.s) + BYTE_W'(4);

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            n_word[8*j +: 8] = frame_byte(i_head.s, i_version, i_pad, i_head.crc,
                                          {r_widx, 3'(j)});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_widx      <= '0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
            r_widx      <= (r_widx == LAST_W) ? '0 : r_widx + WORD_W'(1);
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_word    <= n_word;
            r_idx_out <= 5'(r_widx);
            r_used    <= 6'(used_full);
            r_last    <= (r_widx == LAST_W);
        end
    end

    assign empty        = !r_out_valid;
    assign o_frame_word = r_word;
    assign o_word_index = r_idx_out;
    assign o_bytes_used = r_used;
    assign o_last       = r_last;

    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_last) |-> r_widx == '0)
        else $error("word counter did not wrap after last word");

    a_pop_gives_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_out_valid && r_last)
        else $error("frame released without last word");

endmodule

// ----- hw/rtl/sensor_tlv_frame_packer_core.sv -----
`timescale 1ns / 1ps
// Packs one sensor sample set per item into a 256-byte frame (12-byte header, optional
// IMU/PPG/temperature records, CRC-16/MODBUS record, pad fill) and returns it as 32
// little-endian 64-bit words, one result item per word. The front checksums two frame
// bytes a cycle up to the checksum record, and takes no new item until it has pushed
// the descriptor into the queue. The back emits one word a cycle while the queue holds
// a frame and the consumer pops each word. A two-entry queue between them lets the next
// item be checksummed while the current frame drains. Configuration writes are always
// taken (ready is tied high) and must only occur while the block is idle.
module sensor_tlv_frame_packer_core import stpk_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    input  logic               push,
    output logic               full,
    input  logic               i_imu_present,
    input  logic               i_ppg_present,
    input  logic               i_temp_present,
    input  logic [31:0]        i_uptime_ms,
    input  logic [47:0]        i_accel_xyz,
    input  logic [47:0]        i_gyro_xyz,
    input  logic [17:0]        i_ir_count,
    input  logic [17:0]        i_red_count,
    input  logic [11:0]        i_pulse_rate_x10,
    input  logic signed [15:0] i_temp_centi_c,
    output logic               empty,
    input  logic               pop,
    output logic [63:0]        o_frame_word,
    output logic [4:0]         o_word_index,
    output logic [5:0]         o_bytes_used,
    output logic               o_last
);

    logic [7:0] r_pad;
    logic [7:0] r_version;
    t_sample    sample;
    t_desc      front_desc;
    t_desc      head;
    t_q_ctl     q_ctl;
    t_q_sts     q_sts;
    logic       q_push;
    logic       q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad     <= PAD_RESET;
            r_version <= VER_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_PAD)     r_pad     <= i_cfg_data;
            if (i_cfg_index == REG_VERSION) r_version <= i_cfg_data;
        end
    end

    assign sample = '{imu_present: i_imu_present, ppg_present: i_ppg_present,
                      temp_present: i_temp_present, uptime_ms: i_uptime_ms,
                      accel_xyz: i_accel_xyz, gyro_xyz: i_gyro_xyz,
                      ir_count: i_ir_count, red_count: i_red_count,
                      pulse_rate_x10: i_pulse_rate_x10, temp_centi_c: i_temp_centi_c};

    assign q_ctl = '{push: q_push, pop: q_pop};

    stpk_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_sample  (sample),
        .i_version (r_version),
        .i_q_sts   (q_sts),
        .o_q_push  (q_push),
        .o_desc    (front_desc)
    );

    stpk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (q_ctl),
        .i_desc  (front_desc),
        .o_sts   (q_sts),
        .o_head  (head)
    );

    stpk_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_q_sts      (q_sts),
        .o_q_pop      (q_pop),
        .i_version    (r_version),
        .i_pad        (r_pad),
        .empty        (empty),
        .pop          (pop),
        .o_frame_word (o_frame_word),
        .o_word_index (o_word_index),
        .o_bytes_used (o_bytes_used),
        .o_last       (o_last)
    );

endmodule
